// ===== hdl/kftt_pkg.sv =====
// Package for the key frequency top-three table.
// Holds the command opcodes and the control/status bundles shared by
// the controller and the datapath. No dependencies.
package kftt_pkg;

  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_COUNT_BITS = 32;
  localparam int OPCODE_BITS    = 3;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 3'd0,
    OP_HIT    = 3'd1,
    OP_QUERY  = 3'd2,
    OP_TOP1   = 3'd3,
    OP_TOP3   = 3'd4
  } opcode_e_t;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic update;
    logic emit;
  } kftt_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic out_free;
    logic last_slot;
  } kftt_status_t;

endpackage

// ===== hdl/key_frequency_top_three_table.sv =====
// Key frequency top-three table, top level.
// Input channel s_*: one command item. tuser[2:0] opcode (insert, count hit,
//   query, top one, top three), tdata key zero-padded to whole bytes.
// Output channel m_*: result items. tdata holds key_out, hit_count and
//   entry_count from the lowest bit up; tuser[0] found, tuser[1] table_full;
//   tlast marks the final result of a command.
// Every command scans the used entries one per cycle from a single memory
//   read port; the next command can be taken in the cycle after the last
//   result is loaded. Top three emits up to three results, one per cycle
//   while m_tready stays high.
// One command is in work at a time; s_tready is high only when idle. The
//   last result waits in the output register while the next command is taken.
// Reset (rst, synchronous) empties the table and drops any pending result.
// When m_tready is low the result holds and the block stalls before the next.
// Depends on kftt_pkg, kftt_ctrl and kftt_dpath.
module key_frequency_top_three_table #(
  parameter int ENTRIES    = kftt_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = kftt_pkg::DEF_KEY_BITS,
  parameter int COUNT_BITS = kftt_pkg::DEF_COUNT_BITS,
  parameter int CNT_W      = $clog2(ENTRIES + 1),
  parameter int ID_W       = ((KEY_BITS + 7) / 8) * 8,
  parameter int OD_W       = ((KEY_BITS + COUNT_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ID_W-1:0]                  s_tdata,  // key
  input  logic [kftt_pkg::OPCODE_BITS-1:0] s_tuser,  // opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [OD_W-1:0]                  m_tdata,  // key_out, hit_count, entry_count
  output logic [1:0]                       m_tuser,  // found, table_full
  output logic                             m_tlast
);
  import kftt_pkg::*;

  kftt_cmd_t    cmd;
  kftt_status_t status;

  kftt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  kftt_dpath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      ($clog2(ENTRIES)),
    .CNT_W      (CNT_W),
    .ID_W       (ID_W),
    .OD_W       (OD_W)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ===== hdl/kftt_ctrl.sv =====
// Controller for the key frequency top-three table.
// Sequences accept, table scan, table update and result emission.
// Depends on kftt_pkg.
module kftt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output kftt_pkg::kftt_cmd_t    cmd,
  input  kftt_pkg::kftt_status_t status
);
  import kftt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = !status.issue_done;
        if (status.issue_done && !status.pipe_busy) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.last_slot) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/kftt_dpath.sv =====
// Datapath for the key frequency top-three table.
// Holds the key/count memories, scan pipeline, ranking registers and the
// output register. Depends on kftt_pkg.
module kftt_dpath #(
  parameter int ENTRIES    = kftt_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = kftt_pkg::DEF_KEY_BITS,
  parameter int COUNT_BITS = kftt_pkg::DEF_COUNT_BITS,
  parameter int IDX_W      = $clog2(ENTRIES),
  parameter int CNT_W      = $clog2(ENTRIES + 1),
  parameter int ID_W       = ((KEY_BITS + 7) / 8) * 8,
  parameter int OD_W       = ((KEY_BITS + COUNT_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ID_W-1:0]               s_tdata,
  input  logic [kftt_pkg::OPCODE_BITS-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OD_W-1:0]               m_tdata,
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast,
  input  kftt_pkg::kftt_cmd_t            cmd,
  output kftt_pkg::kftt_status_t         status
);
  import kftt_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [KEY_BITS-1:0]   mem_key [ENTRIES];
  logic [COUNT_BITS-1:0] mem_cnt [ENTRIES];

  opcode_e_t             op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [CNT_W-1:0]      rd_addr;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  logic [KEY_BITS-1:0]   key_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [CNT_W-1:0]      used;
  logic                  match;
  logic [IDX_W-1:0]      match_idx;
  logic [COUNT_BITS-1:0] match_cnt;
  logic                  res_found;
  logic                  res_full;
  logic [1:0]            emit_idx;

  logic [KEY_BITS-1:0]   slot_key [3];
  logic [COUNT_BITS-1:0] slot_cnt [3];
  logic [COUNT_BITS-1:0] thr      [3];
  logic [KEY_BITS-1:0]   base_key [3];
  logic [COUNT_BITS-1:0] base_cnt [3];
  logic [COUNT_BITS-1:0] base_thr [3];
  logic [KEY_BITS-1:0]   slot_key_next [3];
  logic [COUNT_BITS-1:0] slot_cnt_next [3];
  logic [COUNT_BITS-1:0] thr_next      [3];

  logic                  wr_en;
  logic                  wr_key_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  room;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic                  o_found;
  logic [KEY_BITS-1:0]   o_key;
  logic [COUNT_BITS-1:0] o_cnt;
  logic                  o_full;
  logic [1:0]            num_res;
  logic                  o_last;

  assign room    = used < CNT_W'(ENTRIES);
  assign cnt_inc = (match_cnt == COUNT_MAX) ? match_cnt : match_cnt + 1'b1;

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      key_rd <= mem_key[rd_addr[IDX_W-1:0]];
      cnt_rd <= mem_cnt[rd_addr[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem_cnt[wr_addr] <= wr_cnt;
      if (wr_key_en) begin
        mem_key[wr_addr] <= wr_key;
      end
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_key_en = 1'b0;
    wr_addr   = used[IDX_W-1:0];
    wr_key    = key_q;
    wr_cnt    = '0;
    if (cmd.update) begin
      case (op_q)
        OP_INSERT: begin
          wr_en     = !match && room;
          wr_key_en = 1'b1;
        end
        OP_HIT: begin
          wr_en   = match;
          wr_addr = match_idx;
          wr_cnt  = cnt_inc;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // top-three ranking; entry 0 is the default for every slot
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base_key[i] = (rd_idx == '0) ? key_rd : slot_key[i];
      base_cnt[i] = (rd_idx == '0) ? cnt_rd : slot_cnt[i];
      base_thr[i] = (rd_idx == '0) ? '0 : thr[i];
      slot_key_next[i] = base_key[i];
      slot_cnt_next[i] = base_cnt[i];
      thr_next[i]      = base_thr[i];
    end
    if (used == CNT_W'(2)) begin
      if (rd_idx != '0) begin
        if (!(base_cnt[0] > cnt_rd)) begin
          slot_key_next[0] = key_rd;
          slot_cnt_next[0] = cnt_rd;
          slot_key_next[1] = base_key[0];
          slot_cnt_next[1] = base_cnt[0];
        end else begin
          slot_key_next[1] = key_rd;
          slot_cnt_next[1] = cnt_rd;
        end
      end
    end else if (cnt_rd > base_thr[0]) begin
      slot_key_next[2] = base_key[1];
      slot_cnt_next[2] = base_cnt[1];
      thr_next[2]      = base_thr[1];
      slot_key_next[1] = base_key[0];
      slot_cnt_next[1] = base_cnt[0];
      thr_next[1]      = base_thr[0];
      slot_key_next[0] = key_rd;
      slot_cnt_next[0] = cnt_rd;
      thr_next[0]      = cnt_rd;
    end else if (cnt_rd > base_thr[1]) begin
      slot_key_next[2] = base_key[1];
      slot_cnt_next[2] = base_cnt[1];
      thr_next[2]      = base_thr[1];
      slot_key_next[1] = key_rd;
      slot_cnt_next[1] = cnt_rd;
      thr_next[1]      = cnt_rd;
    end else if (cnt_rd > base_thr[2]) begin
      slot_key_next[2] = key_rd;
      slot_cnt_next[2] = cnt_rd;
      thr_next[2]      = cnt_rd;
    end
  end

  // command capture, scan and update
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.update && op_q == OP_INSERT && !match && room) begin
        used <= used + 1'b1;
      end
    end
    rd_idx <= rd_addr[IDX_W-1:0];
    if (cmd.start) begin
      op_q    <= opcode_e_t'(s_tuser);
      key_q   <= s_tdata[KEY_BITS-1:0];
      rd_addr <= '0;
      match   <= 1'b0;
    end else if (cmd.scan_rd) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (rd_vld) begin
      case (op_q)
        OP_TOP1: begin
          if (rd_idx == '0 || cnt_rd > slot_cnt[0]) begin
            slot_key[0] <= key_rd;
            slot_cnt[0] <= cnt_rd;
          end
        end
        OP_TOP3: begin
          for (int i = 0; i < 3; i++) begin
            slot_key[i] <= slot_key_next[i];
            slot_cnt[i] <= slot_cnt_next[i];
            thr[i]      <= thr_next[i];
          end
        end
        default: begin
          if (!match && key_rd == key_q) begin
            match     <= 1'b1;
            match_idx <= rd_idx;
            match_cnt <= cnt_rd;
          end
        end
      endcase
    end
    if (cmd.update) begin
      emit_idx <= '0;
      case (op_q)
        OP_INSERT: begin
          res_found <= match || room;
          res_full  <= !match && !room;
          if (!match) begin
            match_cnt <= '0;
          end
        end
        OP_HIT: begin
          res_found <= match;
          res_full  <= 1'b0;
          if (match) begin
            match_cnt <= cnt_inc;
          end
        end
        default: begin
          res_found <= match;
          res_full  <= 1'b0;
        end
      endcase
    end else if (cmd.emit) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // result selection
  always_comb begin
    o_found = 1'b0;
    o_key   = '0;
    o_cnt   = '0;
    o_full  = 1'b0;
    num_res = 2'd1;
    case (op_q)
      OP_INSERT, OP_HIT, OP_QUERY: begin
        o_found = res_found;
        o_key   = key_q;
        o_cnt   = res_found ? match_cnt : '0;
        o_full  = res_full;
      end
      OP_TOP1: begin
        if (used != '0) begin
          o_found = 1'b1;
          o_key   = slot_key[0];
          o_cnt   = slot_cnt[0];
        end
      end
      OP_TOP3: begin
        if (used == CNT_W'(2)) begin
          num_res = 2'd2;
        end else if (used > CNT_W'(2)) begin
          num_res = 2'd3;
        end
        if (used != '0) begin
          o_found = 1'b1;
          case (emit_idx)
            2'd0: begin
              o_key = slot_key[0];
              o_cnt = slot_cnt[0];
            end
            2'd1: begin
              o_key = slot_key[1];
              o_cnt = slot_cnt[1];
            end
            default: begin
              o_key = slot_key[2];
              o_cnt = slot_cnt[2];
            end
          endcase
        end
      end
      default: begin
        o_key = key_q;
      end
    endcase
    o_last = emit_idx == (num_res - 2'd1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.emit) begin
      m_tdata <= OD_W'({used, o_cnt, o_key});
      m_tuser <= {o_full, o_found};
      m_tlast <= o_last;
    end
  end

  assign status.issue_done = rd_addr >= used;
  assign status.pipe_busy  = rd_vld;
  assign status.out_free   = !m_tvalid || m_tready;
  assign status.last_slot  = o_last;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(ENTRIES))
    else $error("entry count above table size");
  a_used_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.update |=> $stable(used))
    else $error("entry count changed outside update");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken item");
  a_no_read_update: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !rd_vld && !cmd.scan_rd)
    else $error("table update while a scan read is pending");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for key_frequency_top_three_table: directed and random
// commands over the stream ports, checked against a table mirror held here.
// Depends on kftt_pkg and the block's RTL.
module testbench;
  import kftt_pkg::*;

  localparam int ENTRIES  = DEF_ENTRIES;
  localparam int KEY_W    = DEF_KEY_BITS;
  localparam int COUNT_W  = DEF_COUNT_BITS;
  localparam int USED_W   = $clog2(ENTRIES + 1);
  localparam int OD_W     = ((KEY_W + COUNT_W + USED_W + 7) / 8) * 8;
  localparam int POOL     = 72;
  localparam int HOT      = 10;
  localparam int RAND_LEN = 160;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  typedef struct {
    opcode_e_t        op;
    logic [KEY_W-1:0] key;
    bit               drain;
  } command_t;

  typedef struct {
    bit                 found;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] hits;
    logic [USED_W-1:0]  used;
    bit                 full;
    bit                 last;
  } table_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [KEY_W-1:0]   s_tdata = '0;  // key
  logic [2:0]         s_tuser = '0;  // opcode
  logic               m_tvalid;
  logic               m_tready = 1'b1;
  logic [OD_W-1:0]    m_tdata;       // key_out, hit_count, entry_count
  logic [1:0]         m_tuser;       // found, table_full
  logic               m_tlast;

  logic [KEY_W-1:0]   mirror_keys[ENTRIES];
  logic [COUNT_W-1:0] mirror_counts[ENTRIES];
  int                 mirror_used = 0;

  command_t           commands[$];
  table_reply_t       awaited[$];
  logic [KEY_W-1:0]   key_pool[POOL];
  int                 total_commands = 0;
  int                 accepted = 0;
  int                 fail_count = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 stall_mode = 0;
  int                 stall_timer = 0;

  key_frequency_top_three_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int find_key(logic [KEY_W-1:0] key);
    for (int i = 0; i < mirror_used; i++)
      if (mirror_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic void push_reply(bit found, logic [KEY_W-1:0] key,
                                     logic [COUNT_W-1:0] hits, bit full, bit last);
    table_reply_t r;
    r.found = found;
    r.key   = key;
    r.hits  = hits;
    r.used  = USED_W'(mirror_used);
    r.full  = full;
    r.last  = last;
    awaited.insert(awaited.size(), r);
  endfunction

  function automatic void push_entry(int idx, bit last);
    push_reply(1'b1, mirror_keys[idx], mirror_counts[idx], 1'b0, last);
  endfunction

  function automatic void apply_command(opcode_e_t op, logic [KEY_W-1:0] key);
    int                 pos;
    int                 best;
    int                 p1, p2, p3;
    logic [COUNT_W-1:0] t1, t2, t3, c;
    pos = find_key(key);
    case (op)
      OP_INSERT: begin
        if (pos >= 0) begin
          push_reply(1'b1, key, mirror_counts[pos], 1'b0, 1'b1);
        end else if (mirror_used < ENTRIES) begin
          mirror_keys[mirror_used]   = key;
          mirror_counts[mirror_used] = '0;
          mirror_used++;
          push_reply(1'b1, key, '0, 1'b0, 1'b1);
        end else begin
          push_reply(1'b0, key, '0, 1'b1, 1'b1);
        end
      end
      OP_HIT: begin
        if (pos >= 0) begin
          if (mirror_counts[pos] != COUNT_TOP) mirror_counts[pos]++;
          push_reply(1'b1, key, mirror_counts[pos], 1'b0, 1'b1);
        end else begin
          push_reply(1'b0, key, '0, 1'b0, 1'b1);
        end
      end
      OP_QUERY: begin
        if (pos >= 0) push_reply(1'b1, key, mirror_counts[pos], 1'b0, 1'b1);
        else push_reply(1'b0, key, '0, 1'b0, 1'b1);
      end
      OP_TOP1: begin
        if (mirror_used == 0) begin
          push_reply(1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          best = 0;
          for (int i = 1; i < mirror_used; i++)
            if (mirror_counts[i] > mirror_counts[best]) best = i;
          push_entry(best, 1'b1);
        end
      end
      OP_TOP3: begin
        if (mirror_used == 0) begin
          push_reply(1'b0, '0, '0, 1'b0, 1'b1);
        end else if (mirror_used == 1) begin
          push_entry(0, 1'b1);
        end else if (mirror_used == 2) begin
          if (mirror_counts[0] > mirror_counts[1]) begin
            push_entry(0, 1'b0);
            push_entry(1, 1'b1);
          end else begin
            push_entry(1, 1'b0);
            push_entry(0, 1'b1);
          end
        end else begin
          t1 = '0; t2 = '0; t3 = '0;
          p1 = 0; p2 = 0; p3 = 0;
          for (int i = 0; i < mirror_used; i++) begin
            c = mirror_counts[i];
            if (c > t1) begin
              t3 = t2; t2 = t1; t1 = c;
              p3 = p2; p2 = p1; p1 = i;
            end else if (c > t2) begin
              t3 = t2; t2 = c;
              p3 = p2; p2 = i;
            end else if (c > t3) begin
              t3 = c;
              p3 = i;
            end
          end
          push_entry(p1, 1'b0);
          push_entry(p2, 1'b0);
          push_entry(p3, 1'b1);
        end
      end
      default: push_reply(1'b0, key, '0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void add_command(opcode_e_t op, logic [KEY_W-1:0] key, bit drain = 0);
    command_t cmd;
    cmd.op    = op;
    cmd.key   = key;
    cmd.drain = drain;
    commands.insert(commands.size(), cmd);
    total_commands++;
  endfunction

  function automatic void add_random_commands(int count);
    int               pick;
    int               sel;
    opcode_e_t        op;
    logic [KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 9);
      if (pick < 22) op = OP_INSERT;
      else if (pick < 60) op = OP_HIT;
      else if (pick < 75) op = OP_QUERY;
      else if (pick < 87) op = OP_TOP1;
      else op = OP_TOP3;
      if (op == OP_INSERT) key = (sel == 0) ? $urandom() : key_pool[$urandom_range(0, POOL - 1)];
      else if (sel < 6) key = key_pool[$urandom_range(0, HOT - 1)];
      else if (sel < 9) key = key_pool[$urandom_range(0, POOL - 1)];
      else key = $urandom();
      add_command(op, key);
    end
  endfunction

  // Send with random bursts and gaps; hold a drain item until all results are back.
  always @(posedge clk) begin
    command_t cmd;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_command(opcode_e_t'(s_tuser), s_tdata);
        accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || commands.size() == 0 ||
            (commands[0].drain && awaited.size() != 0)) begin
          s_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          cmd = commands.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cmd.key;
          s_tuser  <= cmd.op;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 80);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Check each result against the oldest expectation; stall in changing modes.
  always @(posedge clk) begin
    table_reply_t exp;
    if (rst) begin
      m_tready <= 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          $error("unexpected result: key_out %h", m_tdata[KEY_W-1:0]);
          fail_count++;
        end else begin
          exp = awaited.pop_front();
          if (m_tuser[0] !== exp.found) begin
            $error("found: expected %0d, got %0d", exp.found, m_tuser[0]);
            fail_count++;
          end
          if (m_tdata[KEY_W-1:0] !== exp.key) begin
            $error("key_out: expected %h, got %h", exp.key, m_tdata[KEY_W-1:0]);
            fail_count++;
          end
          if (m_tdata[KEY_W+COUNT_W-1:KEY_W] !== exp.hits) begin
            $error("hit_count: expected %0d, got %0d", exp.hits,
                   m_tdata[KEY_W+COUNT_W-1:KEY_W]);
            fail_count++;
          end
          if (m_tdata[KEY_W+COUNT_W+USED_W-1:KEY_W+COUNT_W] !== exp.used) begin
            $error("entry_count: expected %0d, got %0d", exp.used,
                   m_tdata[KEY_W+COUNT_W+USED_W-1:KEY_W+COUNT_W]);
            fail_count++;
          end
          if (m_tuser[1] !== exp.full) begin
            $error("table_full: expected %0d, got %0d", exp.full, m_tuser[1]);
            fail_count++;
          end
          if (m_tlast !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, m_tlast);
            fail_count++;
          end
        end
      end
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 2);
        stall_timer = $urandom_range(20, 150);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    for (int i = 0; i < POOL; i++) key_pool[i] = $urandom();

    add_command(OP_TOP1, $urandom());
    add_command(OP_TOP3, $urandom());
    add_command(OP_QUERY, '0);
    add_command(OP_HIT, '0);
    add_command(OP_INSERT, '1);
    add_command(OP_TOP3, '0);
    add_command(OP_INSERT, '0);
    add_command(OP_TOP3, '0);
    add_command(OP_HIT, '1);
    add_command(OP_TOP3, '0);
    add_command(OP_HIT, '0);
    add_command(OP_HIT, '0);
    add_command(OP_TOP3, '0);
    add_command(OP_INSERT, '0);
    add_command(OP_QUERY, '1);
    add_command(OP_INSERT, 32'h5555_AAAA);
    add_command(OP_TOP3, '0);
    add_command(OP_TOP1, '0);
    add_command(OP_INSERT, 32'hAAAA_5555);
    add_command(OP_HIT, 32'hAAAA_5555);
    add_command(OP_HIT, 32'hAAAA_5555);
    add_command(OP_HIT, 32'hAAAA_5555);
    add_command(OP_TOP3, '0);
    add_command(OP_TOP1, '0);

    add_random_commands(RAND_LEN);
    for (int i = 0; i < POOL; i++) add_command(OP_INSERT, key_pool[i], i == 0);
    add_command(OP_INSERT, $urandom());
    add_command(OP_TOP3, '0);
    add_command(OP_TOP1, '0);
    add_random_commands(RAND_LEN);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted < total_commands) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (ENTRIES + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
